// File: design/number_to_digit_cells_top_defines.svh
`ifndef NUMBER_TO_DIGIT_CELLS_TOP_DEFINES_SVH
`define NUMBER_TO_DIGIT_CELLS_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, held off during rst
`define NTDC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, held off during rst
`define NTDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ntdc_pkg.sv
`default_nettype none

package ntdc_pkg;

  localparam int NUM_DIGITS   = 10;
  localparam int DIGIT_IDX_W  = $clog2(NUM_DIGITS);
  localparam int VALUE_BITS   = 31;
  localparam int BIT_CNT_W    = $clog2(VALUE_BITS);
  localparam int MAX_CELLS    = 32;
  localparam int CAP_W        = 6;
  localparam int CODE_W       = 8;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 8;
  localparam int MODE_W       = 2;

  localparam int TIME_CELLS   = 5;
  localparam int TIME_BITS    = 13;
  localparam int MIN_BITS     = 7;
  localparam int COMB_BITS    = 14;
  localparam int RECIP_60     = 8739;
  localparam int RECIP_W      = 14;
  localparam int RECIP_SHIFT  = 19;
  localparam int TIME_LIMIT   = 6000;
  localparam int SAT_TIME     = 9959;

  localparam logic [MODE_W-1:0] MODE_PLAIN  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TIME   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SIGNED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_PAD      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_CAPACITY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLON_CODE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIGN_CODE     = 3'd4;

  localparam logic [CAP_W-1:0]  RESET_CAPACITY = 6'd8;
  localparam logic [CODE_W-1:0] RESET_COLON    = 8'd10;
  localparam logic [CODE_W-1:0] RESET_SIGN     = 8'd11;

  typedef logic [3:0] bcd_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } chain_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SUM,
    S_CONV,
    S_PREP,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

// File: design/number_to_digit_cells_top.sv
// A number is converted by a 31-step shift-and-adjust pass through the row of ten
// digit cells before its cells are emitted; emission stalls under back-pressure.
// The final cell may wait at the output while the next number is taken.
// Reset: rst is synchronous; control state clears and the registers take
// mode plain, no padding, capacity 8, colon 10, sign 11. No clearing pass.
`default_nettype none

module number_to_digit_cells_top
  import ntdc_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    cfg_wr_en,
  input  wire  [CFG_IDX_W-1:0]   cfg_index,
  input  wire  [CFG_DATA_W-1:0]  cfg_data,
  input  wire  signed [31:0]     number_in,
  input  wire                    in_valid,
  output logic                   in_ready,
  output logic [CODE_W-1:0]      cell_code,
  output logic                   last_cell,
  output logic                   out_valid,
  input  wire                    out_ready
);

  state_t state, state_next;

  logic [MODE_W-1:0]  display_mode;
  logic               zero_pad;
  logic [CAP_W-1:0]   cell_capacity;
  logic [CODE_W-1:0]  colon_code;
  logic [CODE_W-1:0]  sign_code;

  logic [VALUE_BITS-1:0] val;
  logic [MIN_BITS-1:0]   minutes;
  logic [VALUE_BITS-1:0] bin;
  logic [BIT_CNT_W-1:0]  bit_cnt;
  logic [CAP_W-1:0]      rem;
  logic [CAP_W-1:0]      idx;
  logic [2:0]            pos;
  logic                  sign_pend;

  chain_ctrl_t                chain_ctrl;
  logic [NUM_DIGITS-1:0][3:0] digits;
  logic                       emit_load;
  logic                       accept;

  logic                                    time_mode;
  logic                                    signed_mode;
  logic [TIME_BITS+RECIP_W-1:0]            prod;
  logic [COMB_BITS-1:0]                    tcomb;
  logic [CAP_W-1:0]                        cap_eff;
  logic [CAP_W-1:0]                        ndig;
  logic [CAP_W-1:0]                        room;
  logic [CAP_W-1:0]                        shown;
  logic [CAP_W-1:0]                        time_cells;
  logic [CODE_W-1:0]                       next_code;

  assign time_mode   = (display_mode == MODE_TIME);
  assign signed_mode = (display_mode == MODE_SIGNED);
  assign accept      = in_valid && in_ready;

  ntdc_cell_chain u_chain (
    .clk    (clk),
    .ctrl   (chain_ctrl),
    .bit_in (bin[VALUE_BITS-1]),
    .digits (digits)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_MUL;
      S_MUL:  state_next = S_SUM;
      S_SUM:  state_next = S_CONV;
      S_CONV: if (bit_cnt == '0) state_next = S_PREP;
      S_PREP: state_next = S_EMIT;
      S_EMIT: if (emit_load && rem == CAP_W'(1)) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready         = 1'b0;
    chain_ctrl.clear = 1'b0;
    chain_ctrl.shift = 1'b0;
    emit_load        = 1'b0;
    unique case (state)
      S_IDLE: in_ready = 1'b1;
      S_SUM:  chain_ctrl.clear = 1'b1;
      S_CONV: chain_ctrl.shift = 1'b1;
      S_EMIT: emit_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_comb begin
    prod  = (TIME_BITS+RECIP_W)'(val[TIME_BITS-1:0]) * (TIME_BITS+RECIP_W)'(RECIP_60);
    tcomb = (val >= VALUE_BITS'(TIME_LIMIT)) ? COMB_BITS'(SAT_TIME) :
            COMB_BITS'(val[TIME_BITS-1:0]) + COMB_BITS'({minutes, 5'b0})
            + COMB_BITS'({minutes, 3'b0});
  end

  always_comb begin
    if (cell_capacity == '0) begin
      cap_eff = CAP_W'(1);
    end else if (cell_capacity > CAP_W'(MAX_CELLS)) begin
      cap_eff = CAP_W'(MAX_CELLS);
    end else begin
      cap_eff = cell_capacity;
    end
    ndig = CAP_W'(1);
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (digits[i] != 4'd0) ndig = CAP_W'(i + 1);
    end
    room  = cap_eff - CAP_W'(signed_mode);
    shown = ndig;
    if (zero_pad && room > shown) shown = room;
    if (shown > room) shown = room;
    if (!signed_mode && shown == '0) shown = CAP_W'(1);
    time_cells = (cap_eff < CAP_W'(TIME_CELLS)) ? cap_eff : CAP_W'(TIME_CELLS);
  end

  always_comb begin
    if (time_mode) begin
      case (pos)
        3'd0:    next_code = CODE_W'(digits[3]);
        3'd1:    next_code = CODE_W'(digits[2]);
        3'd2:    next_code = colon_code;
        3'd3:    next_code = CODE_W'(digits[1]);
        default: next_code = CODE_W'(digits[0]);
      endcase
    end else if (sign_pend) begin
      next_code = sign_code;
    end else if (idx < CAP_W'(NUM_DIGITS)) begin
      next_code = CODE_W'(digits[idx[DIGIT_IDX_W-1:0]]);
    end else begin
      next_code = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      display_mode  <= MODE_PLAIN;
      zero_pad      <= 1'b0;
      cell_capacity <= RESET_CAPACITY;
      colon_code    <= RESET_COLON;
      sign_code     <= RESET_SIGN;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_DISPLAY_MODE:  display_mode  <= cfg_data[MODE_W-1:0];
          REG_ZERO_PAD:      zero_pad      <= cfg_data[0];
          REG_CELL_CAPACITY: cell_capacity <= cfg_data[CAP_W-1:0];
          REG_COLON_CODE:    colon_code    <= cfg_data;
          REG_SIGN_CODE:     sign_code     <= cfg_data;
          default: ;
        endcase
      end
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      val <= number_in[31] ? '0 : number_in[VALUE_BITS-1:0];
    end
    if (state == S_MUL) begin
      minutes <= prod[RECIP_SHIFT +: MIN_BITS];
    end
    if (state == S_SUM) begin
      bin     <= time_mode ? VALUE_BITS'(tcomb) : val;
      bit_cnt <= BIT_CNT_W'(VALUE_BITS - 1);
    end
    if (state == S_CONV) begin
      bin     <= {bin[VALUE_BITS-2:0], 1'b0};
      bit_cnt <= bit_cnt - BIT_CNT_W'(1);
    end
    if (state == S_PREP) begin
      pos       <= '0;
      sign_pend <= signed_mode;
      idx       <= shown - CAP_W'(1);
      rem       <= time_mode ? time_cells : shown + CAP_W'(signed_mode);
    end
    if (emit_load) begin
      cell_code <= next_code;
      last_cell <= (rem == CAP_W'(1));
      rem       <= rem - CAP_W'(1);
      if (time_mode) begin
        pos <= pos + 3'd1;
      end else if (sign_pend) begin
        sign_pend <= 1'b0;
      end else begin
        idx <= idx - CAP_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: design/ntdc_digit_cell.sv
`default_nettype none

module ntdc_digit_cell
  import ntdc_pkg::*;
(
  input  wire         clk,
  input  chain_ctrl_t ctrl,
  input  wire         carry_in,
  output logic        carry_out,
  output bcd_t        digit
);

  bcd_t adj;

  always_comb begin
    adj       = (digit >= 4'd5) ? digit + 4'd3 : digit;
    carry_out = adj[3];
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= '0;
    end else if (ctrl.shift) begin
      digit <= {adj[2:0], carry_in};
    end
  end

endmodule

`default_nettype wire

// File: design/ntdc_cell_chain.sv
`default_nettype none

module ntdc_cell_chain
  import ntdc_pkg::*;
(
  input  wire                         clk,
  input  chain_ctrl_t                 ctrl,
  input  wire                         bit_in,
  output logic [NUM_DIGITS-1:0][3:0]  digits
);

  logic [NUM_DIGITS:0] carry;

  assign carry[0] = bit_in;

  for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
    ntdc_digit_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .carry_in  (carry[g]),
      .carry_out (carry[g+1]),
      .digit     (digits[g])
    );
  end

endmodule

`default_nettype wire

// File: design/ntdc_checker.sv
`default_nettype none
`include "number_to_digit_cells_top_defines.svh"

module ntdc_checker
  import ntdc_pkg::*;
(
  input wire              clk,
  input wire              rst,
  input wire              in_valid,
  input wire              in_ready,
  input wire [CODE_W-1:0] cell_code,
  input wire              last_cell,
  input wire              out_valid,
  input wire              out_ready
);

  `NTDC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(cell_code) && $stable(last_cell), "stalled cell code changed")
  `NTDC_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second number taken during conversion")
  `NTDC_ASSERT_NOW(a_only_last_waits, in_valid && in_ready && out_valid, last_cell, "number taken while cells still pending")
  `NTDC_ASSERT_NEXT(a_no_gap, out_valid && out_ready && !last_cell, out_valid, "gap inside a cell sequence")

endmodule

bind number_to_digit_cells_top ntdc_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .cell_code (cell_code),
  .last_cell (last_cell),
  .out_valid (out_valid),
  .out_ready (out_ready)
);

`default_nettype wire

// File: tb/sv/tb_number_to_digit_cells_top.sv
module tb_number_to_digit_cells_top
  import ntdc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 80;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 50;
  localparam int NUM_ROWS     = 25;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              pad;
    logic [CAP_W-1:0]  cap;
    logic [CODE_W-1:0] colon;
    logic [CODE_W-1:0] sign;
  } display_setting_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              last;
  } digit_cell_t;

  typedef struct packed {
    display_setting_t   setting;
    logic [31:0]        number;
    logic [3:0]         n_typed;
    logic [0:7][7:0]    typed;
  } stimulus_row_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE
  } ready_style_t;

  localparam display_setting_t CFG_RESET =
    '{MODE_PLAIN, 1'b0, RESET_CAPACITY, RESET_COLON, RESET_SIGN};
  localparam display_setting_t CFG_PAD8      = '{MODE_PLAIN, 1'b1, 6'd8, 8'd10, 8'd11};
  localparam display_setting_t CFG_CAP1      = '{MODE_PLAIN, 1'b0, 6'd1, 8'd10, 8'd11};
  localparam display_setting_t CFG_CAP0      = '{MODE_PLAIN, 1'b0, 6'd0, 8'd10, 8'd11};
  localparam display_setting_t CFG_PAD63     = '{MODE_PLAIN, 1'b1, 6'd63, 8'd10, 8'd11};
  localparam display_setting_t CFG_CAP32     = '{MODE_PLAIN, 1'b0, 6'd32, 8'd10, 8'd11};
  localparam display_setting_t CFG_TIME8     = '{MODE_TIME, 1'b0, 6'd8, 8'd10, 8'd11};
  localparam display_setting_t CFG_TIME3     = '{MODE_TIME, 1'b0, 6'd3, 8'd255, 8'd11};
  localparam display_setting_t CFG_TIME1     = '{MODE_TIME, 1'b0, 6'd1, 8'd255, 8'd11};
  localparam display_setting_t CFG_SIGN1     = '{MODE_SIGNED, 1'b0, 6'd1, 8'd10, 8'd200};
  localparam display_setting_t CFG_SIGN8     = '{MODE_SIGNED, 1'b0, 6'd8, 8'd10, 8'd11};
  localparam display_setting_t CFG_SIGNPAD4  = '{MODE_SIGNED, 1'b1, 6'd4, 8'd10, 8'd11};
  localparam display_setting_t CFG_SIGN4     = '{MODE_SIGNED, 1'b0, 6'd4, 8'd10, 8'd11};
  localparam display_setting_t CFG_MODE3     = '{MODE_UNUSED, 1'b0, 6'd8, 8'd10, 8'd11};
  localparam display_setting_t CFG_MODE3PAD2 = '{MODE_UNUSED, 1'b1, 6'd2, 8'd10, 8'd11};
  localparam display_setting_t CFG_SIGNPAD32 = '{MODE_SIGNED, 1'b1, 6'd32, 8'd10, 8'd255};

  localparam stimulus_row_t DIRECTED [NUM_ROWS] = '{
    '{CFG_RESET, 32'd0, 4'd1, {8'd0, 56'd0}},
    '{CFG_RESET, 32'h7FFF_FFFF, 4'd8,
      {8'd4, 8'd7, 8'd4, 8'd8, 8'd3, 8'd6, 8'd4, 8'd7}},
    '{CFG_RESET, 32'hFFFF_FFFF, 4'd1, {8'd0, 56'd0}},
    '{CFG_RESET, 32'h8000_0000, 4'd1, {8'd0, 56'd0}},
    '{CFG_RESET, 32'd12345, 4'd0, 64'd0},
    '{CFG_PAD8, 32'd42, 4'd8, {48'd0, 8'd4, 8'd2}},
    '{CFG_CAP1, 32'd987, 4'd1, {8'd7, 56'd0}},
    '{CFG_CAP0, 32'd5, 4'd1, {8'd5, 56'd0}},
    '{CFG_PAD63, 32'd7, 4'd0, 64'd0},
    '{CFG_CAP32, 32'h7FFF_FFFF, 4'd0, 64'd0},
    '{CFG_TIME8, 32'd0, 4'd5, {8'd0, 8'd0, 8'd10, 8'd0, 8'd0, 24'd0}},
    '{CFG_TIME8, 32'd3599, 4'd5, {8'd5, 8'd9, 8'd10, 8'd5, 8'd9, 24'd0}},
    '{CFG_TIME8, 32'd5999, 4'd5, {8'd9, 8'd9, 8'd10, 8'd5, 8'd9, 24'd0}},
    '{CFG_TIME8, 32'd6000, 4'd5, {8'd9, 8'd9, 8'd10, 8'd5, 8'd9, 24'd0}},
    '{CFG_TIME8, 32'h7FFF_FFFF, 4'd5, {8'd9, 8'd9, 8'd10, 8'd5, 8'd9, 24'd0}},
    '{CFG_TIME8, 32'hFFFF_FFFB, 4'd5, {8'd0, 8'd0, 8'd10, 8'd0, 8'd0, 24'd0}},
    '{CFG_TIME3, 32'd754, 4'd3, {8'd1, 8'd2, 8'd255, 40'd0}},
    '{CFG_TIME1, 32'd754, 4'd1, {8'd1, 56'd0}},
    '{CFG_SIGN1, 32'd123, 4'd1, {8'd200, 56'd0}},
    '{CFG_SIGN8, 32'd0, 4'd2, {8'd11, 8'd0, 48'd0}},
    '{CFG_SIGNPAD4, 32'd5, 4'd4, {8'd11, 8'd0, 8'd0, 8'd5, 32'd0}},
    '{CFG_SIGN4, 32'd123456, 4'd4, {8'd11, 8'd4, 8'd5, 8'd6, 32'd0}},
    '{CFG_MODE3, 32'd905, 4'd3, {8'd9, 8'd0, 8'd5, 40'd0}},
    '{CFG_MODE3PAD2, 32'd905, 4'd2, {8'd0, 8'd5, 48'd0}},
    '{CFG_SIGNPAD32, 32'hFFFF_FFF9, 4'd0, 64'd0}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic signed [31:0]    number_in = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CODE_W-1:0]     cell_code;
  logic                  last_cell;
  logic                  out_valid;
  logic                  out_ready = 1'b0;

  display_setting_t active_cfg = CFG_RESET;
  digit_cell_t      expected_cells [$];

  int mismatch_count = 0;
  int cells_checked = 0;
  int numbers_sent = 0;
  int settings_applied = 0;
  int hold_requests = 0;
  int holds_started = 0;
  int hold_left = 0;
  int style_left = 0;
  int stall_cycles = 0;
  int burst_left = 0;
  ready_style_t ready_style = READY_ALWAYS;

  number_to_digit_cells_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .number_in (number_in),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cell_code (cell_code),
    .last_cell (last_cell),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 40) $display("%0t ns mismatch: %s", $time, what);
  endtask

  task automatic format_cells(input logic [31:0] num);
    logic [31:0]       value;
    logic [31:0]       minutes;
    logic [31:0]       seconds;
    logic [31:0]       rest;
    logic [CODE_W-1:0] cells [MAX_CELLS];
    logic [3:0]        digits [16];
    logic              is_signed;
    int                cap;
    int                count;
    int                ndig;
    int                room;
    int                shown;
    digit_cell_t       entry;
    value = num[31] ? 32'd0 : num;
    cap = int'(active_cfg.cap);
    if (cap < 1) cap = 1;
    if (cap > MAX_CELLS) cap = MAX_CELLS;
    count = 0;
    if (active_cfg.mode == MODE_TIME) begin
      minutes = value / 60;
      seconds = value % 60;
      if (minutes > 99) begin
        minutes = 99;
        seconds = 59;
      end
      cells[0] = CODE_W'(minutes / 10);
      cells[1] = CODE_W'(minutes % 10);
      cells[2] = active_cfg.colon;
      cells[3] = CODE_W'(seconds / 10);
      cells[4] = CODE_W'(seconds % 10);
      count = (cap < TIME_CELLS) ? cap : TIME_CELLS;
    end else begin
      ndig = 0;
      rest = value;
      do begin
        digits[ndig] = 4'(rest % 10);
        ndig++;
        rest = rest / 10;
      end while (rest > 0 && ndig < 16);
      is_signed = (active_cfg.mode == MODE_SIGNED);
      room = cap - (is_signed ? 1 : 0);
      shown = ndig;
      if (active_cfg.pad && room > shown) shown = room;
      if (shown > room) shown = room;
      if (!is_signed && shown < 1) shown = 1;
      if (is_signed) begin
        cells[count] = active_cfg.sign;
        count++;
      end
      for (int i = shown - 1; i >= 0; i--) begin
        cells[count] = (i < ndig) ? CODE_W'(digits[i]) : '0;
        count++;
      end
    end
    for (int i = 0; i < count; i++) begin
      entry.code = cells[i];
      entry.last = (i == count - 1);
      expected_cells.push_back(entry);
    end
  endtask

  task automatic apply_setting(input display_setting_t s);
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = REG_DISPLAY_MODE;
    cfg_data  = CFG_DATA_W'(s.mode);
    @(negedge clk);
    cfg_index = REG_ZERO_PAD;
    cfg_data  = CFG_DATA_W'(s.pad);
    @(negedge clk);
    cfg_index = REG_CELL_CAPACITY;
    cfg_data  = CFG_DATA_W'(s.cap);
    @(negedge clk);
    cfg_index = REG_COLON_CODE;
    cfg_data  = s.colon;
    @(negedge clk);
    cfg_index = REG_SIGN_CODE;
    cfg_data  = s.sign;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    cfg_data  = CFG_DATA_W'($urandom);
    active_cfg = s;
    settings_applied++;
  endtask

  task automatic pause_sender(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid  = 1'b0;
      number_in = $urandom;
    end
  endtask

  task automatic send_number(input logic [31:0] num, input logic [3:0] n_typed,
                             input logic [0:7][7:0] typed);
    digit_cell_t entry;
    @(negedge clk);
    number_in = num;
    in_valid  = 1'b1;
    do @(posedge clk); while (!in_ready);
    numbers_sent++;
    if (n_typed != 0) begin
      for (int i = 0; i < int'(n_typed); i++) begin
        entry.code = typed[i];
        entry.last = (i == int'(n_typed) - 1);
        expected_cells.push_back(entry);
      end
    end else begin
      format_cells(num);
    end
  endtask

  function automatic display_setting_t random_setting();
    display_setting_t s;
    s.mode = MODE_W'($urandom_range(0, 3));
    s.pad  = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: s.cap = CAP_W'($urandom_range(1, 6));
      1: begin
        case ($urandom_range(0, 3))
          0: s.cap = 6'd0;
          1: s.cap = 6'd1;
          2: s.cap = 6'd32;
          default: s.cap = 6'd63;
        endcase
      end
      default: s.cap = CAP_W'($urandom_range(0, 63));
    endcase
    s.colon = CODE_W'($urandom_range(0, 255));
    s.sign  = CODE_W'($urandom_range(0, 255));
    return s;
  endfunction

  function automatic logic [31:0] random_number();
    logic [31:0] n;
    logic [31:0] p;
    case ($urandom_range(0, 9))
      0, 1: n = $urandom_range(0, 99);
      2, 3: n = $urandom_range(0, 7000);
      4: n = 32'h8000_0000 | $urandom;
      5, 6: n = $urandom;
      7: begin
        p = 1;
        repeat ($urandom_range(0, 9)) p = p * 10;
        n = p + $urandom_range(0, 2) - 1;
      end
      default: begin
        case ($urandom_range(0, 7))
          0: n = 32'd0;
          1: n = 32'd59;
          2: n = 32'd60;
          3: n = 32'd5999;
          4: n = 32'd6000;
          5: n = 32'h7FFF_FFFF;
          6: n = 32'h8000_0000;
          default: n = 32'hFFFF_FFFF;
        endcase
      end
    endcase
    return n;
  endfunction

  always @(posedge clk) begin : check_cells
    digit_cell_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_cells.size() == 0) begin
        report_mismatch($sformatf("unexpected cell code %0d last %0b", cell_code, last_cell));
      end else begin
        want = expected_cells.pop_front();
        if (cell_code !== want.code)
          report_mismatch($sformatf("cell %0d: code %0d, want %0d",
                                    cells_checked, cell_code, want.code));
        if (last_cell !== want.last)
          report_mismatch($sformatf("cell %0d: last_cell %0b, want %0b",
                                    cells_checked, last_cell, want.last));
        cells_checked++;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else if (holds_started < hold_requests) begin
      holds_started++;
      hold_left = HOLD_CYCLES - 1;
      out_ready = 1'b0;
    end else begin
      if (style_left == 0) begin
        ready_style = ready_style_t'($urandom_range(0, 2));
        style_left  = $urandom_range(5, 60);
      end
      style_left--;
      case (ready_style)
        READY_ALWAYS: out_ready = 1'b1;
        READY_COIN:   out_ready = 1'($urandom_range(0, 1));
        default:      out_ready = ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    display_setting_t s;
    number_in = $urandom;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int r = 0; r < NUM_ROWS; r++) begin
      if (DIRECTED[r].setting != active_cfg) apply_setting(DIRECTED[r].setting);
      pause_sender($urandom_range(0, 3));
      send_number(DIRECTED[r].number, DIRECTED[r].n_typed, DIRECTED[r].typed);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: s = '{MODE_PLAIN, 1'b1, 6'd32, 8'd0, 8'd255};
        1: s = '{MODE_TIME, 1'b0, 6'd1, 8'd255, 8'd0};
        2: s = '{MODE_SIGNED, 1'b1, 6'd63, 8'd0, 8'd255};
        3: s = '{MODE_UNUSED, 1'b0, 6'd0, 8'd255, 8'd0};
        default: s = random_setting();
      endcase
      apply_setting(s);
      burst_left = 0;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 5 && k == 10) hold_requests++;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
        end
        burst_left--;
        send_number(random_number(), 4'd0, 64'd0);
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d cell codes from %0d numbers under %0d register settings",
             cells_checked, numbers_sent, settings_applied);
    $display("plain, time, signed and unused modes, capacities 0 to 63, %0d long output hold",
             holds_started);
    if (mismatch_count == 0 && expected_cells.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
